### src/dnv_pkg.sv
// Package for the domain name validator: register indexes, field widths,
// the per-name state type and the character class helper. No dependencies.
package dnv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_NAME_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LABEL_LENGTH = 1'd1;

    localparam logic [COUNT_W-1:0] RST_MAX_NAME_LENGTH  = 8'd253;
    localparam logic [COUNT_W-1:0] RST_MAX_LABEL_LENGTH = 8'd63;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 8'd255;

    localparam logic [BYTE_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_DOT    = 8'h2E;

    typedef struct packed {
        logic [COUNT_W-1:0] total_count;
        logic [COUNT_W-1:0] label_count;
        logic               at_label_start;
        logic               prev_alnum;
        logic               error_seen;
    } t_name_state;

    localparam t_name_state NAME_STATE_CLEAR = '{
        total_count:    '0,
        label_count:    '0,
        at_label_start: 1'b1,
        prev_alnum:     1'b0,
        error_seen:     1'b0
    };

    function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) ||
               (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

### src/dnv_if.sv
// Channel interfaces of the domain name validator: byte input, verdict
// output and configuration write. Depends on dnv_pkg.
interface dnv_in_if import dnv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] name_byte;
    logic              last_byte;

    modport source (output valid, output name_byte, output last_byte, input ready);
    modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface dnv_out_if;
    logic valid;
    logic ready;
    logic name_valid;

    modport source (output valid, output name_valid, input ready);
    modport sink   (input valid, input name_valid, output ready);
endinterface

interface dnv_cfg_if import dnv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COUNT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/dnv_step.sv
// Per-byte update of the name state: character class, label rules and
// saturating length counters. Depends on dnv_pkg.
module dnv_step import dnv_pkg::*; (
    input  logic [BYTE_W-1:0]  i_name_byte,
    input  t_name_state        i_state,
    input  logic [COUNT_W-1:0] i_max_name_length,
    input  logic [COUNT_W-1:0] i_max_label_length,
    output t_name_state        o_state,
    output logic               o_name_valid
);

    logic               w_alnum;
    logic               w_dot;
    logic               w_hyphen;
    logic               w_total_sat;
    logic               w_label_sat;
    logic [COUNT_W-1:0] w_total_next;
    logic [COUNT_W-1:0] w_label_inc;
    logic               w_err;

    always_comb begin
        w_alnum  = is_alnum(i_name_byte);
        w_dot    = (i_name_byte == CHAR_DOT);
        w_hyphen = (i_name_byte == CHAR_HYPHEN);

        w_total_sat  = (i_state.total_count == COUNT_SAT);
        w_total_next = w_total_sat ? i_state.total_count : i_state.total_count + 8'd1;
        w_label_sat  = (i_state.label_count == COUNT_SAT);
        w_label_inc  = w_label_sat ? i_state.label_count : i_state.label_count + 8'd1;

        w_err = i_state.error_seen || w_total_sat || (w_total_next > i_max_name_length);

        o_state = i_state;
        o_state.total_count = w_total_next;

        if (w_dot) begin
            if (i_state.at_label_start || !i_state.prev_alnum) begin
                w_err = 1'b1;
            end
            o_state.label_count    = '0;
            o_state.at_label_start = 1'b1;
            o_state.prev_alnum     = 1'b0;
        end else if (w_alnum || w_hyphen) begin
            // A hyphen may not open a label; both classes count toward its length.
            if (w_hyphen && i_state.at_label_start) begin
                w_err = 1'b1;
            end
            if (w_label_sat || (w_label_inc > i_max_label_length)) begin
                w_err = 1'b1;
            end
            o_state.label_count    = w_label_inc;
            o_state.at_label_start = 1'b0;
            o_state.prev_alnum     = w_alnum;
        end else begin
            w_err = 1'b1;
            o_state.at_label_start = 1'b0;
            o_state.prev_alnum     = 1'b0;
        end

        o_state.error_seen = w_err;
        o_name_valid = !w_err && !o_state.at_label_start && o_state.prev_alnum;
    end

endmodule

### src/domain_name_validator.sv
// Top level of the domain name validator: input register, state update and
// verdict register. Depends on dnv_pkg, the dnv_*_if interfaces and dnv_step.
//
// How to use this block:
// A domain name is sent on i_in one byte per item, in order, with last_byte
// set on its final byte. Only the final byte produces a result: one item on
// o_out whose name_valid is 1 when the name is a well-formed host name (labels
// of letters, digits and inner hyphens, separated by single dots, within the
// label and name length limits). Other bytes produce nothing.
// Two limits are written on i_cfg: index 0 is the greatest name length and
// index 1 the greatest label length. Write them only while no name is in
// progress. The configuration channel is always ready.
// Timing: a byte is captured in the input register; the state update then runs
// on it there and, for a final byte, the verdict is loaded into the output
// register once that register is free. One byte is accepted every cycle
// while no final byte waits in the input register, since the state update
// is a single short compare-and-increment step.
// When the receiver stalls, the verdict waits in the output register; further
// non-final bytes keep flowing, and a final byte waits in the input register
// until the output register is free, which then holds off i_in.
// Reset (synchronous, active low) empties both registers, restores the limits
// to 253 and 63, and clears the per-name state.
module domain_name_validator import dnv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dnv_in_if.sink        i_in,
    dnv_out_if.source     o_out,
    dnv_cfg_if.sink       i_cfg
);

    // Limit registers.
    logic [COUNT_W-1:0] r_max_name_length;
    logic [COUNT_W-1:0] r_max_label_length;

    // Input register.
    logic               r_s_valid;
    logic [BYTE_W-1:0]  r_s_byte;
    logic               r_s_last;

    // Name state and output register.
    t_name_state        r_state;
    t_name_state        n_state;
    logic               r_out_valid;
    logic               r_out_name_valid;

    logic               w_out_free;
    logic               w_s_fire;
    logic               w_in_accept;
    logic               w_verdict;

    dnv_step u_step (
        .i_name_byte        (r_s_byte),
        .i_state            (r_state),
        .i_max_name_length  (r_max_name_length),
        .i_max_label_length (r_max_label_length),
        .o_state            (n_state),
        .o_name_valid       (w_verdict)
    );

    // A non-final byte never needs the output register; a final one does.
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_s_fire    = r_s_valid && (!r_s_last || w_out_free);
    assign i_in.ready  = !r_s_valid || w_s_fire;
    assign w_in_accept = i_in.valid && i_in.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.name_valid = r_out_name_valid;
    assign i_cfg.ready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name_length  <= RST_MAX_NAME_LENGTH;
            r_max_label_length <= RST_MAX_LABEL_LENGTH;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_NAME_LENGTH:  r_max_name_length  <= i_cfg.data;
                REG_MAX_LABEL_LENGTH: r_max_label_length <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s_byte <= i_in.name_byte;
            r_s_last <= i_in.last_byte;
        end
    end

    // The final byte hands out its verdict and returns the state to clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NAME_STATE_CLEAR;
        end else if (w_s_fire) begin
            r_state <= r_s_last ? NAME_STATE_CLEAR : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s_fire && r_s_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_s_fire && r_s_last) begin
            r_out_name_valid <= w_verdict;
        end
    end

endmodule

### src/dnv_checker.sv
// Port-level checks for the domain name validator, bound to its top level.
// Depends on dnv_pkg and domain_name_validator.
module dnv_checker import dnv_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [BYTE_W-1:0] i_in_name_byte,
    input logic              i_in_last_byte,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_name_valid
);

    logic w_last_accept;
    assign w_last_accept = i_in_valid && i_in_ready && i_in_last_byte;

    // A stalled verdict is held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_name_valid))
        else $error("verdict changed or dropped while stalled");

    // Reset leaves no verdict pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("verdict present after reset");

    // A fresh verdict follows an accepted final byte.
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_last_accept, 2))
        else $error("verdict without a final byte");

    // A name that ends in anything but a letter or digit is never valid.
    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) && i_out_name_valid |-> $past(is_alnum(i_in_name_byte), 2))
        else $error("valid verdict for a name not ending in a letter or digit");

endmodule

bind domain_name_validator dnv_checker u_dnv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_name_byte   (i_in.name_byte),
    .i_in_last_byte   (i_in.last_byte),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_name_valid (o_out.name_valid)
);
